// File: rtl/bpa_pkg.sv
// Shared types, constants and saturating counter helpers for the bitmap page allocator.
// No dependencies; imported by every module of the block but bpa_map_ram.
package bpa_pkg;

    localparam int CNT_W     = 17;
    localparam int IDX_W     = 16;
    localparam int MODE_W    = 3;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int BIT_IDX_W = 6;
    localparam int BIT_CNT_W = 7;

    localparam int DEF_MAX_PAGES     = 65536;
    localparam int DEF_MAP_WORD_BITS = 64;
    localparam int DEF_TOTAL_PAGES   = 65536;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [MODE_W-1:0] MODE_ALLOC     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FREE      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LOCK      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RESERVE   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_UNRESERVE = 3'd4;

    // register index, taken from paddr[2]
    localparam logic REG_IDX_TOTAL = 1'b0;

    typedef struct packed {
        logic                 any;
        logic [BIT_IDX_W-1:0] first;
        logic [BIT_CNT_W-1:0] count;
    } word_stat_t;

    function automatic logic [CNT_W-1:0] cnt_add_sat(input logic [CNT_W-1:0] c,
                                                     input logic [BIT_CNT_W-1:0] n);
        logic [CNT_W:0] s;
        s = {1'b0, c} + (CNT_W+1)'(n);
        return (s > {1'b0, CNT_MAX}) ? CNT_MAX : s[CNT_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] cnt_sub_sat(input logic [CNT_W-1:0] c,
                                                     input logic [BIT_CNT_W-1:0] n);
        return (c < CNT_W'(n)) ? '0 : c - CNT_W'(n);
    endfunction

endpackage

// File: rtl/bitmap_page_allocator.sv
// Channel  | Ports                                      | Transfer when
// ---------+--------------------------------------------+------------------------
// command  | s_valid s_ready s_mode s_page_index s_page_count   | s_valid & s_ready
// result   | m_valid m_ready m_status m_alloc_page m_*_pages    | m_valid & m_ready
// config   | psel penable pwrite paddr pwdata prdata pready     | psel & penable & pwrite
//
// One command at a time. A range or allocate command reads one map word per cycle
// through the map RAM and writes it back when a bit in it changes; allocate stops at
// the first word with a free page. Empty ranges and unknown modes skip the map.
// After reset a clearing pass writes MAP_DEPTH words (1024 by default) before the first
// command transfer; configuration writes are taken throughout.
// A result waiting on m_ready holds the next command back only once that one has finished.
// Depends on bpa_pkg, bpa_map_ram and bpa_word_unit.
module bitmap_page_allocator import bpa_pkg::*; #(
    parameter int MAX_PAGES     = DEF_MAX_PAGES,
    parameter int MAP_WORD_BITS = DEF_MAP_WORD_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [MODE_W-1:0]   s_mode,
    input  logic [IDX_W-1:0]    s_page_index,
    input  logic [CNT_W-1:0]    s_page_count,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_status,
    output logic [IDX_W-1:0]    m_alloc_page,
    output logic [CNT_W-1:0]    m_changed_pages,
    output logic [CNT_W-1:0]    m_free_pages,
    output logic [CNT_W-1:0]    m_used_pages,
    output logic [CNT_W-1:0]    m_reserved_pages,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    localparam int MAP_DEPTH = (MAX_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int AW        = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int BW        = $clog2(MAP_WORD_BITS);
    localparam logic [CNT_W-1:0] RESET_EFF = (DEF_TOTAL_PAGES > MAX_PAGES) ?
                                             CNT_W'(MAX_PAGES) : CNT_W'(DEF_TOTAL_PAGES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_DEPTH - 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RUN   = 3'd2;
    localparam logic [2:0] ST_FIN   = 3'd3;
    localparam logic [2:0] ST_RESP  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [AW-1:0]     clr_addr_reg;

    logic [MODE_W-1:0] mode_reg;
    logic [CNT_W-1:0]  start_page_reg, endm1_reg;
    logic [AW-1:0]     start_word_reg, last_word_reg, cur_word_reg, rd_word_reg;
    logic              issue_done_reg, rd_valid_reg;

    logic                 acc_valid_reg, acc_any_reg, acc_fail_reg;
    logic [BIT_CNT_W-1:0] acc_n_reg;
    logic [CNT_W-1:0]     acc_low_reg;

    logic [CNT_W-1:0] hint_reg, hint_next;
    logic [CNT_W-1:0] free_reg, free_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [CNT_W-1:0] resv_reg, resv_next;
    logic [CNT_W-1:0] changed_reg, changed_next;
    logic [CNT_W-1:0] alloc_page_reg, alloc_page_next;
    logic             status_reg, status_next;
    logic [CNT_W-1:0] total_raw_reg, total_eff_reg;

    logic             out_valid_reg, out_status_reg;
    logic [IDX_W-1:0] out_alloc_reg;
    logic [CNT_W-1:0] out_changed_reg, out_free_reg, out_used_reg, out_resv_reg;

    logic             accept, cfg_we, is_alloc, mode_ok, go_run, out_load;
    logic [CNT_W-1:0] cfg_eff, range_end, cmd_start, cmd_end;
    logic [CNT_W:0]   end_sum;
    logic             issue, s1_act, s1_last, s1_term;
    logic [CNT_W-1:0] s1_low;
    logic [BW-1:0]    s1_lo, s1_hi;
    logic             set_op;

    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [MAP_WORD_BITS-1:0] ram_wdata, ram_rdata, new_word;
    word_stat_t               stat;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_IDX_TOTAL);
    assign cfg_eff = (PDATA_W'(pwdata[CNT_W-1:0]) > PDATA_W'(MAX_PAGES)) ?
                     CNT_W'(MAX_PAGES) : pwdata[CNT_W-1:0];
    assign prdata = (paddr[2] == REG_IDX_TOTAL) ? PDATA_W'(total_raw_reg) : '0;

    // ---------------- command decode ----------------
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign is_alloc = (s_mode == MODE_ALLOC);
    assign mode_ok  = s_mode inside {MODE_ALLOC, MODE_FREE, MODE_LOCK, MODE_RESERVE,
                                     MODE_UNRESERVE};
    // one bit wider so a range running past the last page cannot wrap
    assign end_sum   = (CNT_W+1)'(s_page_index) + (CNT_W+1)'(s_page_count);
    assign range_end = (end_sum > (CNT_W+1)'(total_eff_reg)) ? total_eff_reg :
                                                                end_sum[CNT_W-1:0];
    assign cmd_start = is_alloc ? hint_reg : CNT_W'(s_page_index);
    assign cmd_end   = is_alloc ? total_eff_reg : range_end;
    assign go_run    = mode_ok && (cmd_start < cmd_end);

    // ---------------- word pipeline ----------------
    // Words are read in ascending order and each changed word is written back the cycle its
    // data arrives, so a read never hits the word being written.
    assign issue   = (state_reg == ST_RUN) && !issue_done_reg;
    assign s1_act  = (state_reg == ST_RUN) && rd_valid_reg;
    assign s1_last = (rd_word_reg == last_word_reg);
    assign s1_lo   = (rd_word_reg == start_word_reg) ? start_page_reg[BW-1:0] : '0;
    assign s1_hi   = s1_last ? endm1_reg[BW-1:0] : '1;
    assign set_op  = (mode_reg == MODE_ALLOC) || (mode_reg == MODE_LOCK) ||
                     (mode_reg == MODE_RESERVE);
    assign s1_low  = CNT_W'({rd_word_reg, stat.first[BW-1:0]});
    assign s1_term = s1_act && (s1_last || ((mode_reg == MODE_ALLOC) && stat.any));

    assign ram_we    = (state_reg == ST_CLEAR) || (s1_act && stat.any);
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg : rd_word_reg;
    assign ram_wdata = (state_reg == ST_CLEAR) ? '0 : new_word;

    bpa_map_ram #(
        .DEPTH (MAP_DEPTH),
        .WIDTH (MAP_WORD_BITS),
        .AW    (AW)
    ) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (issue),
        .raddr (cur_word_reg),
        .rdata (ram_rdata)
    );

    bpa_word_unit #(
        .WORD_BITS (MAP_WORD_BITS),
        .BW        (BW)
    ) u_word (
        .rd_word  (ram_rdata),
        .lo       (s1_lo),
        .hi       (s1_hi),
        .set_op   (set_op),
        .single   (mode_reg == MODE_ALLOC),
        .new_word (new_word),
        .stat     (stat)
    );

    // ---------------- control ----------------
    assign out_load = (state_reg == ST_RESP) && (!out_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_addr_reg == LAST_ADDR) state_next = ST_IDLE;
            ST_IDLE:  if (accept) state_next = go_run ? ST_RUN : ST_RESP;
            ST_RUN:   if (s1_term) state_next = ST_FIN;
            ST_FIN:   state_next = ST_RESP;
            ST_RESP:  if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            issue_done_reg <= 1'b1;
            rd_valid_reg   <= 1'b0;
            acc_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            hint_reg       <= '0;
            free_reg       <= RESET_EFF;
            used_reg       <= '0;
            resv_reg       <= '0;
            total_raw_reg  <= CNT_W'(DEF_TOTAL_PAGES);
            total_eff_reg  <= RESET_EFF;
        end else begin
            state_reg     <= state_next;
            rd_valid_reg  <= issue;
            acc_valid_reg <= s1_act;
            hint_reg      <= hint_next;
            free_reg      <= free_next;
            used_reg      <= used_next;
            resv_reg      <= resv_next;
            if (state_reg == ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (accept) begin
                issue_done_reg <= 1'b0;
            end else if (issue && (cur_word_reg == last_word_reg)) begin
                issue_done_reg <= 1'b1;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                total_raw_reg <= pwdata[CNT_W-1:0];
                total_eff_reg <= cfg_eff;
            end
        end
    end

    // command, pipeline and result payload
    always_ff @(posedge aclk) begin
        changed_reg    <= changed_next;
        status_reg     <= status_next;
        alloc_page_reg <= alloc_page_next;
        if (accept) begin
            mode_reg       <= s_mode;
            start_page_reg <= cmd_start;
            endm1_reg      <= cmd_end - 1'b1;
            start_word_reg <= AW'(cmd_start >> BW);
            last_word_reg  <= AW'((cmd_end - 1'b1) >> BW);
            cur_word_reg   <= AW'(cmd_start >> BW);
        end else if (issue) begin
            cur_word_reg <= cur_word_reg + 1'b1;
        end
        if (issue) begin
            rd_word_reg <= cur_word_reg;
        end
        acc_n_reg    <= stat.count;
        acc_any_reg  <= stat.any;
        acc_low_reg  <= s1_low;
        acc_fail_reg <= (mode_reg == MODE_ALLOC) && !stat.any && s1_last;
        if (out_load) begin
            out_status_reg  <= status_reg;
            out_alloc_reg   <= alloc_page_reg[IDX_W-1:0];
            out_changed_reg <= changed_reg;
            out_free_reg    <= free_reg;
            out_used_reg    <= used_reg;
            out_resv_reg    <= resv_reg;
        end
    end

    // counter update, one word behind the RAM
    always_comb begin
        hint_next       = hint_reg;
        free_next       = free_reg;
        used_next       = used_reg;
        resv_next       = resv_reg;
        changed_next    = changed_reg;
        status_next     = status_reg;
        alloc_page_next = alloc_page_reg;
        if (accept) begin
            changed_next    = '0;
            alloc_page_next = '0;
            status_next     = is_alloc && !go_run;
            if (is_alloc && !go_run) begin
                hint_next = total_eff_reg;
            end
        end
        if (acc_valid_reg) begin
            changed_next = changed_reg + CNT_W'(acc_n_reg);
            case (mode_reg)
                MODE_ALLOC: begin
                    if (acc_fail_reg) begin
                        status_next = 1'b1;
                        hint_next   = total_eff_reg;
                    end else if (acc_any_reg) begin
                        hint_next       = acc_low_reg;
                        alloc_page_next = acc_low_reg;
                        free_next       = cnt_sub_sat(free_reg, acc_n_reg);
                        used_next       = cnt_add_sat(used_reg, acc_n_reg);
                    end
                end
                MODE_LOCK: begin
                    free_next = cnt_sub_sat(free_reg, acc_n_reg);
                    used_next = cnt_add_sat(used_reg, acc_n_reg);
                end
                MODE_RESERVE: begin
                    free_next = cnt_sub_sat(free_reg, acc_n_reg);
                    resv_next = cnt_add_sat(resv_reg, acc_n_reg);
                end
                MODE_FREE: begin
                    free_next = cnt_add_sat(free_reg, acc_n_reg);
                    used_next = cnt_sub_sat(used_reg, acc_n_reg);
                    if (acc_any_reg && (acc_low_reg < hint_reg)) hint_next = acc_low_reg;
                end
                MODE_UNRESERVE: begin
                    free_next = cnt_add_sat(free_reg, acc_n_reg);
                    resv_next = cnt_sub_sat(resv_reg, acc_n_reg);
                    if (acc_any_reg && (acc_low_reg < hint_reg)) hint_next = acc_low_reg;
                end
                default: ;
            endcase
        end
        if (cfg_we) begin
            free_next = cfg_eff;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_status         = out_status_reg;
    assign m_alloc_page     = out_alloc_reg;
    assign m_changed_pages  = out_changed_reg;
    assign m_free_pages     = out_free_reg;
    assign m_used_pages     = out_used_reg;
    assign m_reserved_pages = out_resv_reg;

endmodule

// File: rtl/bpa_map_ram.sv
// Occupancy map storage: one write port, one read port, registered read data.
// Depends on nothing but its parameters.
module bpa_map_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 64,
    parameter int AW    = 10
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_array[waddr] <= wdata;
        end
        if (re) begin
            rd_data_reg <= mem_array[raddr];
        end
    end

    assign rdata = rd_data_reg;

endmodule

// File: rtl/bpa_word_unit.sv
// Per-word modify logic: range mask, changed bits, lowest changed bit, bit count.
// Depends on bpa_pkg.
module bpa_word_unit import bpa_pkg::*; #(
    parameter int WORD_BITS = 64,
    parameter int BW        = 6
) (
    input  logic [WORD_BITS-1:0] rd_word,
    input  logic [BW-1:0]        lo,
    input  logic [BW-1:0]        hi,
    input  logic                 set_op,
    input  logic                 single,
    output logic [WORD_BITS-1:0] new_word,
    output word_stat_t           stat
);

    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] chg;
    logic [BW-1:0]        first_idx;

    always_comb begin
        for (int i = 0; i < WORD_BITS; i++) begin
            mask[i] = (BW'(i) >= lo) && (BW'(i) <= hi);
        end
        chg = set_op ? (mask & ~rd_word) : (mask & rd_word);

        first_idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (chg[i]) begin
                first_idx = BW'(i);
            end
        end

        stat.any   = |chg;
        stat.first = BIT_IDX_W'(first_idx);
        // allocate takes a single page, ranges take every changed bit
        if (single) begin
            stat.count = BIT_CNT_W'(stat.any);
            new_word   = stat.any ? (rd_word | (WORD_BITS'(1) << first_idx)) : rd_word;
        end else begin
            stat.count = BIT_CNT_W'($countones(chg));
            new_word   = rd_word ^ chg;
        end
    end

endmodule

// File: rtl/bpa_checker.sv
// Port-level checks for the bitmap page allocator, bound to the top level.
// Depends on bpa_pkg and bitmap_page_allocator.
module bpa_checker import bpa_pkg::*; (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic             m_status,
    input logic [IDX_W-1:0] m_alloc_page,
    input logic [CNT_W-1:0] m_changed_pages,
    input logic [CNT_W-1:0] m_free_pages
);

    localparam logic [CNT_W-1:0] MAX_RANGE = 17'h10000;

    // one command in flight: no transfer on the cycle after one
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("command accepted back to back");

    a_fail_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status) |-> (m_changed_pages == '0 && m_alloc_page == '0))
        else $error("failed allocate reports a page or a change");

    a_range_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_changed_pages <= MAX_RANGE))
        else $error("changed page count beyond largest range");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            (m_valid && $stable(m_free_pages) && $stable(m_changed_pages)))
        else $error("result dropped or changed while stalled");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (.*);
